// ===== hdl/flrd_pkg.sv =====
package flrd_pkg;

  localparam int GROUND_SAMPLES_DEF = 20;
  localparam int SAT_SLOTS_DEF      = 12;
  localparam int TICK_WRAP_DEF      = 65536;

  localparam int ValW      = 21;
  localparam int NumChan   = 8;
  localparam int ChW       = $clog2(NumChan);
  localparam int MaxOps    = 3;
  localparam int OutDepth  = 4;
  localparam int OutCntW   = $clog2(OutDepth + 1);
  localparam int InDataW   = 48;
  localparam int OutDataW  = 176;

  localparam logic [7:0] REC_FLIGHT = 8'h46;  // F
  localparam logic [7:0] REC_ACCEL  = 8'h41;  // A
  localparam logic [7:0] REC_TEMP   = 8'h54;  // T
  localparam logic [7:0] REC_DEPLOY = 8'h44;  // D
  localparam logic [7:0] REC_STATE  = 8'h53;  // S
  localparam logic [7:0] REC_GTIME  = 8'h47;  // G
  localparam logic [7:0] REC_LAT    = 8'h4e;  // N
  localparam logic [7:0] REC_LON    = 8'h57;  // W
  localparam logic [7:0] REC_ALT    = 8'h48;  // H
  localparam logic [7:0] REC_SAT    = 8'h56;  // V
  localparam logic [7:0] REC_DATE   = 8'h59;  // Y

  localparam logic [ChW-1:0] CH_ACCEL  = 3'd0;
  localparam logic [ChW-1:0] CH_PRES   = 3'd1;
  localparam logic [ChW-1:0] CH_TEMP   = 3'd2;
  localparam logic [ChW-1:0] CH_VOLT   = 3'd3;
  localparam logic [ChW-1:0] CH_DROGUE = 3'd4;
  localparam logic [ChW-1:0] CH_MAIN   = 3'd5;
  localparam logic [ChW-1:0] CH_STATE  = 3'd6;
  localparam logic [ChW-1:0] CH_GPS    = 3'd7;

  localparam logic [3:0] BIT_TIME = 4'b0001;
  localparam logic [3:0] BIT_LAT  = 4'b0010;
  localparam logic [3:0] BIT_LON  = 4'b0100;
  localparam logic [3:0] BIT_ALT  = 4'b1000;
  localparam logic [3:0] MASK_ALL = 4'b1111;

  localparam logic [ValW-1:0] YEAR_BASE = 21'd2000;

  typedef enum logic [2:0] {
    KIND_SAMPLE = 3'd0,
    KIND_FLIGHT = 3'd1,
    KIND_GROUND = 3'd2,
    KIND_FIX    = 3'd3,
    KIND_SAT    = 3'd4,
    KIND_DATE   = 3'd5,
    KIND_REJECT = 3'd6
  } kind_t;

  // one pending result, before the channel time is known
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        chan;
    logic [ChW-1:0]    mch;
    logic              unwrap;
    logic [15:0]       tick;
    logic [ValW-1:0]   value;
    logic [31:0]       lat;
    logic [31:0]       lon;
    logic [15:0]       alt;
    logic [23:0]       aux;
    logic [7:0]        flags;
  } op_t;

  typedef op_t [MaxOps-1:0] op_list_t;

  typedef struct packed {
    logic valid;
    logic last;
    op_t  op;
  } issue_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        chan;
    logic [31:0]       time_res;
    logic [ValW-1:0]   value;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [15:0] altitude;
    logic [23:0]       aux;
    logic [7:0]        gps_flags;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [15:0] wrap;
    logic [31:0] off;
    logic [31:0] last;
  } chan_ent_t;

endpackage

// ===== hdl/flrd_decode.sv =====
module flrd_decode #(
  parameter int GROUND_SAMPLES = flrd_pkg::GROUND_SAMPLES_DEF,
  parameter int SAT_SLOTS      = flrd_pkg::SAT_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   record_type,
  input  logic [15:0]                  tick,
  input  logic [15:0]                  word_a,
  input  logic [15:0]                  word_b,
  output flrd_pkg::op_list_t           new_ops,
  output logic [1:0]                   new_n,
  output logic [flrd_pkg::ValW-1:0]    ground_avg
);
  import flrd_pkg::*;

  // exact reciprocal for sums below 2**ValW
  localparam int DivL = $clog2(GROUND_SAMPLES);
  localparam int DivS = ValW + DivL;
  localparam longint unsigned DivM =
    ((64'd1 << DivS) + 64'(GROUND_SAMPLES) - 64'd1) / 64'(GROUND_SAMPLES);
  localparam int ProdW = DivS + ValW + 1;

  logic [ValW-1:0]  ground_sum, ground_sum_next;
  logic [4:0]       ground_count, ground_count_next;
  logic [15:0]      fix_tick, fix_tick_next;
  logic [31:0]      fix_lat, fix_lat_next;
  logic [31:0]      fix_lon, fix_lon_next;
  logic [15:0]      fix_alt, fix_alt_next;
  logic [23:0]      fix_clock, fix_clock_next;
  logic [7:0]       fix_flag_byte, fix_flag_byte_next;
  logic [3:0]       fix_valid_mask, fix_valid_mask_next;
  logic [15:0]      sat_group_tick, sat_group_tick_next;
  logic [3:0]       sat_group_fill, sat_group_fill_next;
  logic             sat_group_open, sat_group_open_next;
  logic [3:0]       fill_cur;
  logic [ProdW-1:0] avg_prod;

  function automatic op_t sample_op(logic [ChW-1:0] ch, logic [15:0] tk, logic [15:0] val);
    op_t o;
    o        = '0;
    o.kind   = KIND_SAMPLE;
    o.chan   = 4'(ch);
    o.mch    = ch;
    o.unwrap = 1'b1;
    o.tick   = tk;
    o.value  = ValW'(val);
    return o;
  endfunction

  always_comb begin
    new_ops             = '0;
    new_n               = 2'd0;
    ground_sum_next     = ground_sum;
    ground_count_next   = ground_count;
    fix_tick_next       = fix_tick;
    fix_lat_next        = fix_lat;
    fix_lon_next        = fix_lon;
    fix_alt_next        = fix_alt;
    fix_clock_next      = fix_clock;
    fix_flag_byte_next  = fix_flag_byte;
    fix_valid_mask_next = fix_valid_mask;
    sat_group_tick_next = sat_group_tick;
    sat_group_fill_next = sat_group_fill;
    sat_group_open_next = sat_group_open;
    fill_cur = (sat_group_open && sat_group_tick == tick) ? sat_group_fill : 4'd0;

    unique case (record_type)
      REC_FLIGHT: begin
        ground_sum_next    = '0;
        ground_count_next  = '0;
        new_ops[0].kind    = KIND_FLIGHT;
        new_ops[0].value   = ValW'(word_a);
        new_ops[0].aux     = 24'(word_b);
        new_n              = 2'd1;
      end
      REC_ACCEL: begin
        new_ops[0] = sample_op(CH_ACCEL, tick, word_a);
        new_ops[1] = sample_op(CH_PRES, tick, word_b);
        new_n      = 2'd2;
        if (ground_count < 5'(GROUND_SAMPLES)) begin
          ground_sum_next   = ground_sum + ValW'(word_b);
          ground_count_next = ground_count + 5'd1;
          // average value is filled in at issue from the divider
          if (ground_count_next == 5'(GROUND_SAMPLES)) begin
            new_ops[2].kind = KIND_GROUND;
            new_n           = 2'd3;
          end
        end
      end
      REC_TEMP: begin
        new_ops[0] = sample_op(CH_TEMP, tick, word_a);
        new_ops[1] = sample_op(CH_VOLT, tick, word_b);
        new_n      = 2'd2;
      end
      REC_DEPLOY: begin
        new_ops[0] = sample_op(CH_DROGUE, tick, word_a);
        new_ops[1] = sample_op(CH_MAIN, tick, word_b);
        new_n      = 2'd2;
      end
      REC_STATE: begin
        new_ops[0] = sample_op(CH_STATE, tick, word_a);
        new_n      = 2'd1;
      end
      REC_GTIME: begin
        fix_tick_next       = tick;
        fix_clock_next      = {word_a[7:0], word_a[15:8], word_b[7:0]};
        fix_flag_byte_next  = word_b[15:8];
        fix_valid_mask_next = BIT_TIME;
      end
      REC_LAT: begin
        fix_lat_next        = {word_b, word_a};
        fix_valid_mask_next = fix_valid_mask | BIT_LAT;
      end
      REC_LON: begin
        fix_lon_next        = {word_b, word_a};
        fix_valid_mask_next = fix_valid_mask | BIT_LON;
      end
      REC_ALT: begin
        fix_alt_next        = word_a;
        fix_valid_mask_next = fix_valid_mask | BIT_ALT;
      end
      REC_SAT: begin
        sat_group_open_next = 1'b1;
        sat_group_tick_next = tick;
        sat_group_fill_next = fill_cur;
        if (fill_cur < 4'(SAT_SLOTS)) begin
          new_ops[0].kind  = KIND_SAT;
          new_ops[0].chan  = fill_cur;
          new_ops[0].tick  = tick;
          new_ops[0].value = ValW'(word_a);
          new_ops[0].aux   = 24'(word_b[15:8]);
          new_n            = 2'd1;
          sat_group_fill_next = fill_cur + 4'd1;
        end
      end
      REC_DATE: begin
        new_ops[0].kind  = KIND_DATE;
        new_ops[0].value = YEAR_BASE + ValW'(word_a[7:0]);
        new_ops[0].aux   = 24'({word_a[15:8], word_b[7:0]});
        new_n            = 2'd1;
      end
      default: begin
        new_ops[0].kind = KIND_REJECT;
        new_n           = 2'd1;
      end
    endcase

    // the mask only completes on a lat, lon or alt record, which has no other result
    if (fix_valid_mask_next == MASK_ALL) begin
      fix_valid_mask_next = '0;
      new_ops[0].kind     = KIND_FIX;
      new_ops[0].chan     = 4'd0;
      new_ops[0].mch      = CH_GPS;
      new_ops[0].unwrap   = 1'b1;
      new_ops[0].tick     = fix_tick_next;
      new_ops[0].lat      = fix_lat_next;
      new_ops[0].lon      = fix_lon_next;
      new_ops[0].alt      = fix_alt_next;
      new_ops[0].aux      = fix_clock_next;
      new_ops[0].flags    = fix_flag_byte_next;
      new_n               = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_sum     <= '0;
      ground_count   <= '0;
      fix_tick       <= '0;
      fix_lat        <= '0;
      fix_lon        <= '0;
      fix_alt        <= '0;
      fix_clock      <= '0;
      fix_flag_byte  <= '0;
      fix_valid_mask <= '0;
      sat_group_tick <= '0;
      sat_group_fill <= '0;
      sat_group_open <= 1'b0;
    end else if (accept) begin
      ground_sum     <= ground_sum_next;
      ground_count   <= ground_count_next;
      fix_tick       <= fix_tick_next;
      fix_lat        <= fix_lat_next;
      fix_lon        <= fix_lon_next;
      fix_alt        <= fix_alt_next;
      fix_clock      <= fix_clock_next;
      fix_flag_byte  <= fix_flag_byte_next;
      fix_valid_mask <= fix_valid_mask_next;
      sat_group_tick <= sat_group_tick_next;
      sat_group_fill <= sat_group_fill_next;
      sat_group_open <= sat_group_open_next;
    end
  end

  // sum is stable before the average result issues
  always_ff @(posedge clk) begin
    avg_prod <= ProdW'(ground_sum) * ProdW'(DivM);
  end

  assign ground_avg = avg_prod[DivS +: ValW];

endmodule

// ===== hdl/flrd_chan.sv =====
module flrd_chan #(
  parameter int TICK_WRAP = flrd_pkg::TICK_WRAP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  flrd_pkg::issue_t  iss,
  output logic              res_valid,
  output flrd_pkg::result_t res,
  output logic              busy
);
  import flrd_pkg::*;

  localparam logic [31:0] TickWrap32 = 32'(TICK_WRAP);

  chan_ent_t         mem [NumChan];
  chan_ent_t         rd_ent;
  logic [NumChan-1:0] has_sample;
  logic              e_valid;
  logic              e_last;
  op_t               e_op;
  logic              fw_valid;
  logic [ChW-1:0]    fw_ch;
  chan_ent_t         fw_ent;
  chan_ent_t         cur;
  chan_ent_t         ent_next;
  logic [31:0]       t_base;
  logic [31:0]       t_wrap;
  logic [15:0]       wrap_inc;
  logic              back;
  logic              wr_en;

  always_comb begin
    // bypass the write that lands on the same edge as this entry's read
    cur = (fw_valid && fw_ch == e_op.mch) ? fw_ent : rd_ent;
    if (!has_sample[e_op.mch]) begin
      cur = '0;
    end
    t_base   = 32'(e_op.tick) + cur.off;
    t_wrap   = t_base + TickWrap32;
    wrap_inc = cur.wrap + 16'd1;
    back     = has_sample[e_op.mch] && (cur.last > t_base);
    ent_next = cur;
    if (back) begin
      ent_next.wrap = wrap_inc;
      ent_next.off  = (wrap_inc == 16'd0) ? 32'd0 : cur.off + TickWrap32;
      ent_next.last = t_wrap;
    end else begin
      ent_next.last = t_base;
    end
    wr_en = e_valid && e_op.unwrap;
  end

  always_ff @(posedge clk) begin
    if (iss.valid) begin
      rd_ent <= mem[iss.op.mch];
    end
    if (wr_en) begin
      mem[e_op.mch] <= ent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid    <= 1'b0;
      fw_valid   <= 1'b0;
      has_sample <= '0;
    end else begin
      e_valid <= iss.valid;
      if (wr_en) begin
        fw_valid               <= 1'b1;
        has_sample[e_op.mch]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss.valid) begin
      e_op   <= iss.op;
      e_last <= iss.last;
    end
    if (wr_en) begin
      fw_ch  <= e_op.mch;
      fw_ent <= ent_next;
    end
  end

  always_comb begin
    res.kind      = e_op.kind;
    res.chan      = e_op.chan;
    res.time_res  = e_op.unwrap ? ent_next.last : 32'(e_op.tick);
    res.value     = e_op.value;
    res.latitude  = e_op.lat;
    res.longitude = e_op.lon;
    res.altitude  = e_op.alt;
    res.aux       = e_op.aux;
    res.gps_flags = e_op.flags;
    res.last      = e_last;
  end

  assign res_valid = e_valid;
  assign busy      = e_valid;

endmodule

// ===== hdl/flrd_out_fifo.sv =====
module flrd_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  flrd_pkg::result_t             wdata,
  input  logic                          rd,
  output logic                          not_empty,
  output flrd_pkg::result_t             rdata,
  output logic [flrd_pkg::OutCntW-1:0]  count
);
  import flrd_pkg::*;

  localparam int PtrW = $clog2(OutDepth);

  result_t         slots [OutDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            pop;

  assign not_empty = (count != '0);
  assign pop       = rd && not_empty;
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(OutDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(OutDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + OutCntW'(wr) - OutCntW'(pop);
    end
  end

endmodule

// ===== hdl/flight_log_record_decoder.sv =====
// Flight log record decoder. Each accepted record (tuser = type letter) yields zero to three
// result items, sent one per cycle unless the output stalls, with tlast on the final one and
// the result kind in tuser. An item holds the input until its last result issues (not when it
// gives no result); the issue sequencer starts one result per cycle while the queue has room,
// and a record that follows is taken at the same edge as its predecessor's last result issues.
// Per-channel time unwrapping is a read-modify-write of an 8-entry channel memory
// (registered read, bypass for back-to-back use of a channel); a result goes from issue through
// the e stage into a 4-entry output queue, which decouples downstream stalls. The ground
// pressure average is an exact reciprocal multiply, ready in the cycle after the sum changes.
module flight_log_record_decoder #(
  parameter int GROUND_SAMPLES = flrd_pkg::GROUND_SAMPLES_DEF,
  parameter int SAT_SLOTS      = flrd_pkg::SAT_SLOTS_DEF,
  parameter int TICK_WRAP      = flrd_pkg::TICK_WRAP_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [flrd_pkg::InDataW-1:0]   s_tdata,   // tick, word_a, word_b
  input  logic [7:0]                     s_tuser,   // record_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [flrd_pkg::OutDataW-1:0]  m_tdata,   // channel, time_res, value, latitude,
                                                    // longitude, altitude, aux, gps_flags
  output logic [2:0]                     m_tuser,   // kind
  output logic                           m_tlast
);
  import flrd_pkg::*;

  logic              accept;
  op_list_t          new_ops;
  logic [1:0]        new_n;
  logic [ValW-1:0]   ground_avg;
  logic              plan_valid;
  op_list_t          plan_ops;
  logic [1:0]        plan_n;
  logic [1:0]        plan_idx;
  logic              issue_ok;
  logic              issue_last;
  issue_t            iss;
  logic              res_valid;
  result_t           res;
  logic              e_busy;
  result_t           out_res;
  logic [OutCntW-1:0] fifo_count;

  flrd_decode #(
    .GROUND_SAMPLES (GROUND_SAMPLES),
    .SAT_SLOTS      (SAT_SLOTS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .record_type (s_tuser),
    .tick        (s_tdata[15:0]),
    .word_a      (s_tdata[31:16]),
    .word_b      (s_tdata[47:32]),
    .new_ops     (new_ops),
    .new_n       (new_n),
    .ground_avg  (ground_avg)
  );

  // issue only when the queue has room for everything in flight
  assign issue_ok   = plan_valid &&
                      (({1'b0, fifo_count} + (OutCntW + 1)'(e_busy)) < (OutCntW + 1)'(OutDepth - 1)
                       || ({1'b0, fifo_count} + (OutCntW + 1)'(e_busy))
                          == (OutCntW + 1)'(OutDepth - 1));
  assign issue_last = (plan_idx == plan_n - 2'd1);
  assign s_tready   = !plan_valid || (issue_ok && issue_last);
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    iss.valid = issue_ok;
    iss.last  = issue_last;
    iss.op    = plan_ops[plan_idx];
    if (iss.op.kind == KIND_GROUND) begin
      iss.op.value = ground_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (accept && new_n != 2'd0) begin
      plan_valid <= 1'b1;
    end else if (issue_ok && issue_last) begin
      plan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && new_n != 2'd0) begin
      plan_ops <= new_ops;
      plan_n   <= new_n;
      plan_idx <= 2'd0;
    end else if (issue_ok) begin
      plan_idx <= plan_idx + 2'd1;
    end
  end

  flrd_chan #(
    .TICK_WRAP (TICK_WRAP)
  ) u_chan (
    .clk       (clk),
    .rst       (rst),
    .iss       (iss),
    .res_valid (res_valid),
    .res       (res),
    .busy      (e_busy)
  );

  flrd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (res_valid),
    .wdata     (res),
    .rd        (m_tready),
    .not_empty (m_tvalid),
    .rdata     (out_res),
    .count     (fifo_count)
  );

  assign m_tdata = {7'd0, out_res.gps_flags, out_res.aux, out_res.altitude, out_res.longitude,
                    out_res.latitude, out_res.value, out_res.time_res, out_res.chan};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  a_plan_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && new_n != 2'd0 |=> plan_valid)
    else $error("plan not loaded after accepting an item with results");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, fifo_count} + (OutCntW + 1)'(e_busy)) <= (OutCntW + 1)'(OutDepth))
    else $error("results in flight exceed output queue room");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    plan_valid && !issue_last |-> !s_tready)
    else $error("input taken while the current item still has results to issue");

endmodule

// ===== tb/flight_log_record_decoder_checker.sv =====
`timescale 1ns / 1ps

module flight_log_record_decoder_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [flrd_pkg::InDataW-1:0]  s_tdata,   // tick, word_a, word_b
  input  logic [7:0]                    s_tuser,   // record_type
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [flrd_pkg::OutDataW-1:0] m_tdata,   // channel, time_res, value, latitude,
                                                   // longitude, altitude, aux, gps_flags
  input  logic [2:0]                    m_tuser,   // kind
  input  logic                          m_tlast,
  output int                            mismatches,
  output int                            backlog
);
  import flrd_pkg::*;

  // per-channel tick unwrapping
  logic [15:0]     chan_wrap [NumChan];
  logic [31:0]     chan_time [NumChan];
  logic            chan_seen [NumChan];

  // ground pressure average
  logic [ValW-1:0] baro_sum;
  logic [4:0]      baro_count;

  // gps fix being assembled
  logic [15:0]     gps_tick;
  logic [31:0]     gps_lat;
  logic [31:0]     gps_lon;
  logic [15:0]     gps_alt;
  logic [23:0]     gps_clock;
  logic [7:0]      gps_flags_byte;
  logic [3:0]      gps_parts;

  // newest satellite group
  logic [15:0]     sat_tick;
  logic [3:0]      sat_fill;
  logic            sat_open;

  result_t         staged [MaxOps];
  int              n_staged;
  result_t         pending_results [$];
  result_t         got;
  result_t         want;

  function automatic logic [31:0] advance_time(input logic [ChW-1:0] ch,
                                               input logic [15:0] tk);
    logic [31:0] t;
    t = {chan_wrap[ch], tk};
    // time ran backward: one more wrap of the tick counter
    if (chan_seen[ch] && chan_time[ch] > t) begin
      chan_wrap[ch] = chan_wrap[ch] + 16'd1;
      t = t + 32'h0001_0000;
    end
    chan_time[ch] = t;
    chan_seen[ch] = 1'b1;
    return t;
  endfunction

  function automatic void stage(input kind_t k, input logic [3:0] chan,
                                input logic [31:0] tm, input logic [ValW-1:0] val,
                                input logic [31:0] lat, input logic [31:0] lon,
                                input logic [15:0] alt, input logic [23:0] aux,
                                input logic [7:0] flags);
    result_t r;
    r.kind      = k;
    r.chan      = chan;
    r.time_res  = tm;
    r.value     = val;
    r.latitude  = lat;
    r.longitude = lon;
    r.altitude  = alt;
    r.aux       = aux;
    r.gps_flags = flags;
    r.last      = 1'b0;
    staged[n_staged] = r;
    n_staged++;
  endfunction

  function automatic void emit_sample(input logic [ChW-1:0] ch, input logic [15:0] tk,
                                      input logic [15:0] val);
    stage(KIND_SAMPLE, {1'b0, ch}, advance_time(ch, tk), ValW'(val), '0, '0, '0, '0, '0);
  endfunction

  function automatic void decode_record(input logic [7:0] rtype, input logic [15:0] tk,
                                        input logic [15:0] a, input logic [15:0] b);
    logic [31:0] t;
    result_t     r;
    n_staged = 0;
    case (rtype)
      REC_FLIGHT: begin
        baro_sum   = '0;
        baro_count = '0;
        stage(KIND_FLIGHT, 4'd0, '0, ValW'(a), '0, '0, '0, 24'(b), '0);
      end
      REC_ACCEL: begin
        emit_sample(CH_ACCEL, tk, a);
        emit_sample(CH_PRES, tk, b);
        if (baro_count < GROUND_SAMPLES_DEF) begin
          baro_sum   = baro_sum + ValW'(b);
          baro_count = baro_count + 5'd1;
          if (baro_count >= GROUND_SAMPLES_DEF)
            stage(KIND_GROUND, 4'd0, '0, baro_sum / ValW'(baro_count), '0, '0, '0, '0, '0);
        end
      end
      REC_TEMP: begin
        emit_sample(CH_TEMP, tk, a);
        emit_sample(CH_VOLT, tk, b);
      end
      REC_DEPLOY: begin
        emit_sample(CH_DROGUE, tk, a);
        emit_sample(CH_MAIN, tk, b);
      end
      REC_STATE: emit_sample(CH_STATE, tk, a);
      REC_GTIME: begin
        gps_tick       = tk;
        gps_clock      = {a[7:0], a[15:8], b[7:0]};
        gps_flags_byte = b[15:8];
        gps_parts      = BIT_TIME;
      end
      REC_LAT: begin
        gps_lat   = {b, a};
        gps_parts = gps_parts | BIT_LAT;
      end
      REC_LON: begin
        gps_lon   = {b, a};
        gps_parts = gps_parts | BIT_LON;
      end
      REC_ALT: begin
        gps_alt   = a;
        gps_parts = gps_parts | BIT_ALT;
      end
      REC_SAT: begin
        // only the newest group is compared, an older one with this tick is not found
        if (!sat_open || sat_tick != tk) begin
          sat_open = 1'b1;
          sat_tick = tk;
          sat_fill = '0;
        end
        if (sat_fill < SAT_SLOTS_DEF) begin
          stage(KIND_SAT, sat_fill, {16'd0, tk}, ValW'(a), '0, '0, '0, {16'd0, b[15:8]}, '0);
          sat_fill = sat_fill + 4'd1;
        end
      end
      REC_DATE:
        stage(KIND_DATE, 4'd0, '0, YEAR_BASE + ValW'(a[7:0]), '0, '0, '0,
              {8'd0, a[15:8], b[7:0]}, '0);
      default: stage(KIND_REJECT, 4'd0, '0, '0, '0, '0, '0, '0, '0);
    endcase

    if (gps_parts == MASK_ALL) begin
      gps_parts = '0;
      t = advance_time(CH_GPS, gps_tick);
      stage(KIND_FIX, 4'd0, t, '0, gps_lat, gps_lon, gps_alt, gps_clock, gps_flags_byte);
    end

    for (int i = 0; i < n_staged; i++) begin
      r = staged[i];
      r.last = (i == n_staged - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf({"kind %0d ch %0d time %h value %0d lat %h lon %h alt %h",
                      " aux %h flags %h last %b"},
                     r.kind, r.chan, r.time_res, r.value, r.latitude, r.longitude,
                     r.altitude, r.aux, r.gps_flags, r.last);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NumChan; c++) begin
        chan_wrap[c] = '0;
        chan_time[c] = '0;
        chan_seen[c] = 1'b0;
      end
      baro_sum       = '0;
      baro_count     = '0;
      gps_tick       = '0;
      gps_lat        = '0;
      gps_lon        = '0;
      gps_alt        = '0;
      gps_clock      = '0;
      gps_flags_byte = '0;
      gps_parts      = '0;
      sat_tick       = '0;
      sat_fill       = '0;
      sat_open       = 1'b0;
      pending_results.delete();
    end else begin
      // input side first: a result never leaves in the cycle its record enters
      if (s_tvalid && s_tready)
        decode_record(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
      if (m_tvalid && m_tready) begin
        got.kind      = kind_t'(m_tuser);
        got.chan      = m_tdata[3:0];
        got.time_res  = m_tdata[35:4];
        got.value     = m_tdata[56:36];
        got.latitude  = m_tdata[88:57];
        got.longitude = m_tdata[120:89];
        got.altitude  = m_tdata[136:121];
        got.aux       = m_tdata[160:137];
        got.gps_flags = m_tdata[168:161];
        got.last      = m_tlast;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item at %0t: %s", $time, describe(got));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.chan !== want.chan ||
              got.time_res !== want.time_res || got.value !== want.value ||
              got.latitude !== want.latitude || got.longitude !== want.longitude ||
              got.altitude !== want.altitude || got.aux !== want.aux ||
              got.gps_flags !== want.gps_flags || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
    end
    backlog <= pending_results.size();
  end

endmodule

// ===== tb/flight_log_record_decoder_tb.sv =====
`timescale 1ns / 1ps

module flight_log_record_decoder_tb;
  import flrd_pkg::*;

  localparam int DirectedItems = 25;
  localparam int RandomItems   = 245;
  localparam int HoldCycles    = 400;
  localparam int CycleLimit    = 200000;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [7:0]          s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [2:0]          m_tuser;
  logic                m_tlast;

  int          mismatches;
  int          backlog;
  int          cycle_count   = 0;
  int          sent          = 0;
  bit          quiet         = 1'b0;
  bit          hold_go       = 1'b0;
  logic        hold_sink     = 1'b0;
  logic [15:0] cur_tick      = '0;
  logic [15:0] prev_sat_tick = '0;
  logic [7:0]  sample_types [4] = '{REC_ACCEL, REC_TEMP, REC_DEPLOY, REC_STATE};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  flight_log_record_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  flight_log_record_decoder_checker decode_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] rnd_type_idx();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] step_tick();
    cur_tick = cur_tick + 16'($urandom_range(0, 9000));
    return cur_tick;
  endfunction

  // valid stays high from one item to the next when there is no gap
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] tk,
                             input logic [15:0] a, input logic [15:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a, tk};
    s_tuser  <= rtype;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  initial begin : sink
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0 || hold_sink) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_sink) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : hold_off
    wait (hold_go);
    hold_sink <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin : stimulus
    int          pick;
    int          n;
    int          k;
    logic [15:0] tk;
    logic [2:0]  parts;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // unknown letters
    send_record(8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_record(8'hff, 16'hffff, 16'hffff, 16'hffff);
    send_record(REC_FLIGHT, 16'h1234, 16'hffff, 16'h0000);
    send_record(REC_ACCEL, 16'hffff, 16'h0000, 16'hffff);
    // tick runs backward on accel and pres
    send_record(REC_ACCEL, 16'h0001, 16'hffff, 16'h0000);
    send_record(REC_TEMP, 16'h0000, 16'hffff, 16'h0000);
    send_record(REC_DEPLOY, 16'hffff, 16'h0000, 16'hffff);
    send_record(REC_STATE, 16'h8000, 16'hffff, 16'hffff);
    send_record(REC_DATE, 16'h0000, 16'hffff, 16'hffff);
    send_record(REC_DATE, 16'hffff, 16'h0000, 16'h0000);
    // position parts before any time record never complete a fix
    send_record(REC_LAT, 16'h0000, 16'h0000, 16'h8000);
    send_record(REC_LON, 16'h0000, 16'hffff, 16'h7fff);
    send_record(REC_ALT, 16'h0000, 16'h8000, 16'h0000);
    send_record(REC_GTIME, 16'hffff, 16'hffff, 16'hffff);
    send_record(REC_LAT, 16'hffff, 16'hffff, 16'h7fff);
    send_record(REC_LON, 16'hffff, 16'h0000, 16'h8000);
    send_record(REC_ALT, 16'hffff, 16'h7fff, 16'hffff);
    // second fix with a smaller tick wraps the gps channel
    send_record(REC_GTIME, 16'h0000, 16'h0000, 16'h0000);
    send_record(REC_ALT, 16'h0000, 16'h0000, 16'h0000);
    send_record(REC_LAT, 16'h0000, 16'h0000, 16'h0000);
    send_record(REC_LON, 16'h0000, 16'h0000, 16'h0000);
    // satellite groups, then an older tick again opens a fresh group
    send_record(REC_SAT, 16'h0005, 16'hffff, 16'hffff);
    send_record(REC_SAT, 16'h0005, 16'h0000, 16'h0000);
    send_record(REC_SAT, 16'h0006, 16'h1234, 16'h8000);
    send_record(REC_SAT, 16'h0005, 16'h0001, 16'h00ff);

    while (sent < DirectedItems + RandomItems) begin
      pick  = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 5) == 0);
      if (!hold_go && sent >= 140) begin
        // sink holds off while records keep coming, so the output queue fills
        hold_go = 1'b1;
        quiet   = 1'b1;
        repeat (30) send_record(REC_ACCEL, step_tick(), rnd16(), rnd16());
      end else if (pick < 18) begin
        send_record(REC_FLIGHT, rnd16(), rnd16(), rnd16());
        n = $urandom_range(0, 1) ? $urandom_range(20, 24) : $urandom_range(1, 19);
        repeat (n) send_record(REC_ACCEL, step_tick(), rnd16(), rnd16());
      end else if (pick < 33) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_record(sample_types[rnd_type_idx()], step_tick(), rnd16(), rnd16());
      end else if (pick < 53) begin
        send_record(REC_GTIME, step_tick(), rnd16(), rnd16());
        parts = 3'b111;
        if ($urandom_range(0, 5) == 0) parts[2'($urandom_range(0, 2))] = 1'b0;
        while (parts != 3'b000) begin
          k = $urandom_range(0, 2);
          if (parts[2'(k)]) begin
            parts[2'(k)] = 1'b0;
            send_record(k == 0 ? REC_LAT : (k == 1 ? REC_LON : REC_ALT),
                        rnd16(), rnd16(), rnd16());
            if ($urandom_range(0, 7) == 0)
              send_record(REC_STATE, step_tick(), rnd16(), rnd16());
          end
        end
      end else if (pick < 68) begin
        tk = rnd16();
        n  = $urandom_range(0, 1) ? $urandom_range(10, 15) : $urandom_range(1, 9);
        repeat (n) send_record(REC_SAT, tk, rnd16(), rnd16());
        if ($urandom_range(0, 3) == 0)
          send_record(REC_SAT, prev_sat_tick, rnd16(), rnd16());
        prev_sat_tick = tk;
      end else if (pick < 76) begin
        send_record(REC_DATE, rnd16(), rnd16(), rnd16());
      end else if (pick < 88) begin
        n = $urandom_range(1, 3);
        repeat (n) send_record(8'($urandom_range(0, 255)), rnd16(), rnd16(), rnd16());
      end else begin
        // arbitrary ticks, often running backward
        n = $urandom_range(1, 4);
        repeat (n)
          send_record(sample_types[rnd_type_idx()], rnd16(), rnd16(), rnd16());
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
